>>> sv/effect_slot_playback_scheduler_defines.svh
// Assertion macros used by the effect slot scheduler top level.
// No dependencies; included by files that carry concurrent checks.
`ifndef EFFECT_SLOT_PLAYBACK_SCHEDULER_DEFINES_SVH
`define EFFECT_SLOT_PLAYBACK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define ESPSCH_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ESPSCH_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/espsch_pkg.sv
// Types and constants of the effect slot scheduler.
// No dependencies; imported by the cell, converter and top level.
`timescale 1ns / 1ps

package espsch_pkg;

    typedef enum logic [2:0] {
        CMD_UPLOAD = 3'd0,
        CMD_PLAY   = 3'd1,
        CMD_ERASE  = 3'd2,
        CMD_FLUSH  = 3'd3,
        CMD_TICK   = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_INVALID = 3'd1,
        STS_DENIED  = 3'd2,
        STS_BUSY    = 3'd3,
        STS_NOSPACE = 3'd4,
        STS_NOSYS   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_RUN,
        FSM_SETTLE
    } fsm_t;

    // APB register byte addresses
    localparam logic [2:0] ADDR_TPS    = 3'd0;
    localparam logic [2:0] ADDR_PERIOD = 3'd4;

    localparam logic [13:0] TPS_RESET    = 14'd1000;
    localparam logic [9:0]  PERIOD_RESET = 10'd50;
    localparam logic [7:0]  FORCE_ON     = 8'h60;

    // floor(2^32 / 1000); error stays below one unit for 30-bit products
    localparam logic [22:0] RECIP_1000 = 23'd4294967;
    localparam logic [9:0]  MS_PER_S   = 10'd1000;

    // Settle count; covers the 3-stage converter plus the sum stage in each
    // cell with margin
    localparam int unsigned SETTLE_CYCLES = 6;

    // Word that walks down the cell chain
    typedef struct packed {
        logic        valid;
        cmd_t        cmd;
        logic [2:0]  slot;
        logic        alloc_new;
        logic [21:0] owner;
        logic        kind;
        logic [15:0] delay;
        logic [15:0] length;
        logic [31:0] value;
        status_t     status;
        logic [2:0]  id;
        logic        done;
        logic        any;
    } op_t;

endpackage

>>> sv/effect_slot_playback_scheduler.sv
// Top level of the effect slot scheduler: stream ports, APB registers, cell chain.
// Depends on espsch_pkg, espsch_cell and the assertion macro header.
//
//  channel | dir | handshake          | content
//  s_*     | in  | s_tvalid/s_tready  | command word
//  m_*     | out | m_tvalid/m_tready  | status and force report
//  apb     | in  | psel/penable/pready| ticks_per_second, tick_period
//
// A word passes the injection register and then one cell per slot, one slot per
// cycle, until its result enters the holding stage; the sequencer then waits
// while a settle counter loaded with SETTLE_CYCLES counts down and the per-slot
// time converters refill, and only then takes the next word. Reset clears all
// slots and the time counter and is followed by the same settle, as is every
// register write. A result waits in a holding stage while the output is
// stalled; the next word is taken once that stage is free.
`timescale 1ns / 1ps
`include "effect_slot_playback_scheduler_defines.svh"

module effect_slot_playback_scheduler
    import espsch_pkg::*;
#(
    parameter int SLOTS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // slot, alloc_new, owner_id, delay_ms, length_ms, play_value
    input  logic [3:0]  s_tuser,   // cmd, effect_kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // status, slot_id, force_x, force_y
    output logic        m_tuser,   // report_valid
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(SETTLE_CYCLES + 1);

    fsm_t          state_reg, state_next;
    logic [CW-1:0] settle_reg, settle_next;
    logic [13:0]   tps_reg;
    logic [9:0]    period_reg;
    logic [31:0]   now_reg;
    op_t           op0_reg;
    op_t           link [SLOTS+1];
    logic [SLOTS-1:0] chain_valid;
    logic          pend_valid_reg;
    logic [21:0]   pend_data_reg;
    logic          pend_user_reg;
    logic          out_valid_reg;
    logic [21:0]   out_data_reg;
    logic          out_user_reg;
    logic          accept;
    logic          cfg_wr;
    logic          out_load;
    op_t           op_new;
    op_t           tail;
    logic [7:0]    force_val;
    logic          is_tick;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == FSM_IDLE) && !pend_valid_reg;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg    <= TPS_RESET;
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr == ADDR_TPS)
            begin
                tps_reg <= pwdata[13:0];
            end
            else if (paddr == ADDR_PERIOD)
            begin
                period_reg <= pwdata[9:0];
            end
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_TPS:    prdata = {18'b0, tps_reg};
            ADDR_PERIOD: prdata = {22'b0, period_reg};
            default:     prdata = 32'b0;
        endcase
    end

    // Command word with its status preset for the case that no slot acts on it
    always_comb
    begin
        op_new           = '0;
        op_new.valid     = 1'b1;
        op_new.cmd       = cmd_t'(s_tuser[2:0]);
        op_new.kind      = s_tuser[3];
        op_new.slot      = s_tdata[2:0];
        op_new.alloc_new = s_tdata[3];
        op_new.owner     = s_tdata[25:4];
        op_new.delay     = s_tdata[41:26];
        op_new.length    = s_tdata[57:42];
        op_new.value     = s_tdata[89:58];
        case (op_new.cmd)
            CMD_UPLOAD:
            begin
                if (op_new.kind)
                begin
                    op_new.status = STS_INVALID;
                end
                else if (op_new.alloc_new)
                begin
                    op_new.status = STS_NOSPACE;
                end
                else
                begin
                    op_new.status = STS_DENIED;
                end
            end
            CMD_PLAY:  op_new.status = STS_DENIED;
            CMD_ERASE: op_new.status = STS_DENIED;
            CMD_FLUSH: op_new.status = STS_OK;
            CMD_TICK:  op_new.status = STS_OK;
            default:   op_new.status = STS_INVALID;
        endcase
    end

    // Injection and time counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op0_reg <= '0;
            now_reg <= 32'd0;
        end
        else
        begin
            op0_reg <= accept ? op_new : '0;
            if (accept && op_new.cmd == CMD_TICK)
            begin
                now_reg <= now_reg + 32'(period_reg);
            end
        end
    end

    // Cell chain
    assign link[0] = op0_reg;
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        espsch_cell #(.IDX(i)) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .tps    (tps_reg),
            .now    (now_reg),
            .op_in  (link[i]),
            .op_out (link[i+1])
        );
        assign chain_valid[i] = link[i+1].valid;
    end
    assign tail = link[SLOTS];

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        settle_next = settle_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (cfg_wr)
                begin
                    state_next  = FSM_SETTLE;
                    settle_next = CW'(SETTLE_CYCLES);
                end
                else if (accept)
                begin
                    state_next = FSM_RUN;
                end
            end
            FSM_RUN:
            begin
                if (tail.valid)
                begin
                    state_next  = FSM_SETTLE;
                    settle_next = CW'(SETTLE_CYCLES);
                end
            end
            FSM_SETTLE:
            begin
                if (cfg_wr)
                begin
                    settle_next = CW'(SETTLE_CYCLES);
                end
                else if (settle_reg == '0)
                begin
                    state_next = FSM_IDLE;
                end
                else
                begin
                    settle_next = settle_reg - CW'(1);
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= FSM_SETTLE;
            settle_reg <= CW'(SETTLE_CYCLES);
        end
        else
        begin
            state_reg  <= state_next;
            settle_reg <= settle_next;
        end
    end

    // Result holding stage and output register
    assign is_tick   = (tail.cmd == CMD_TICK);
    assign force_val = (is_tick && tail.any) ? FORCE_ON : 8'h00;
    assign out_load  = pend_valid_reg && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (tail.valid)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail.valid)
        begin
            pend_data_reg <= {force_val, force_val, tail.id, tail.status};
            pend_user_reg <= is_tick;
        end
        if (out_load)
        begin
            out_data_reg <= pend_data_reg;
            out_user_reg <= pend_user_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b0, out_data_reg};
    assign m_tuser  = out_user_reg;

    // Checks
    `ESPSCH_ASSERT_IMP(a_one_word_in_chain, clk, rst_n, 1'b1, $onehot0(chain_valid),
        "more than one word in the cell chain")
    `ESPSCH_ASSERT_IMP(a_tail_hold_free, clk, rst_n, tail.valid, !pend_valid_reg,
        "chain result while holding stage full")
    `ESPSCH_ASSERT_NXT(a_accept_injects, clk, rst_n, accept, op0_reg.valid && state_reg == FSM_RUN,
        "accepted word not injected")
    `ESPSCH_ASSERT_IMP(a_report_ok, clk, rst_n, pend_valid_reg && pend_user_reg,
        pend_data_reg[2:0] == STS_OK, "tick report with bad status")

endmodule

>>> sv/espsch_conv.sv
// Milliseconds to time counter units: ms * tps / 1000, three register stages.
// Depends on espsch_pkg for the reciprocal constant.
`timescale 1ns / 1ps

module espsch_conv
    import espsch_pkg::*;
(
    input  logic        clk,
    input  logic [15:0] ms,
    input  logic [13:0] tps,
    output logic [20:0] units
);

    logic [29:0] prod_reg;
    logic [20:0] quot_reg;
    logic [20:0] units_reg;
    logic [52:0] recip_prod;
    logic [29:0] back_prod;
    logic [29:0] rem;

    // Reciprocal estimate is exact or one low; one compare fixes it
    assign recip_prod = 53'(prod_reg) * 53'(RECIP_1000);
    assign back_prod  = 30'(quot_reg) * 30'(MS_PER_S);
    assign rem        = prod_reg - back_prod;

    always_ff @(posedge clk)
    begin
        prod_reg  <= 30'(ms) * 30'(tps);
        quot_reg  <= recip_prod[52:32];
        units_reg <= (rem >= 30'(MS_PER_S)) ? quot_reg + 21'd1 : quot_reg;
    end

    assign units = units_reg;

endmodule

>>> sv/espsch_cell.sv
// One effect slot: entry state plus the stage of the command chain over it.
// Depends on espsch_pkg and espsch_conv.
`timescale 1ns / 1ps

module espsch_cell
    import espsch_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [13:0] tps,
    input  logic [31:0] now,
    input  op_t         op_in,
    output op_t         op_out
);

    localparam logic [6:0] IDX_W = 7'(IDX);

    logic        used_reg,    used_next;
    logic        started_reg, started_next;
    logic        playing_reg, playing_next;
    logic [21:0] owner_reg,   owner_next;
    logic [15:0] delay_reg,   delay_next;
    logic [15:0] length_reg,  length_next;
    logic [30:0] count_reg,   count_next;
    logic [31:0] start_reg,   start_next;
    logic [21:0] sum_reg;
    op_t         op_reg,      op_next;

    logic [20:0] dly_units;
    logic [20:0] len_units;
    logic        match;
    logic        touch;
    logic [31:0] run_end;
    logic [31:0] dly_end;
    logic        run_over;
    logic        dly_over;

    // Time conversion of delay and length
    espsch_conv u_conv_dly (.clk(clk), .ms(delay_reg),  .tps(tps), .units(dly_units));
    espsch_conv u_conv_len (.clk(clk), .ms(length_reg), .tps(tps), .units(len_units));

    always_ff @(posedge clk)
    begin
        sum_reg <= 22'(dly_units) + 22'(len_units);
    end

    // Ownership and wrapped time compares
    assign match    = ({4'b0, op_in.slot} == IDX_W);
    assign touch    = used_reg && (op_in.owner == 22'd0 || owner_reg == op_in.owner);
    assign run_end  = start_reg + 32'(sum_reg);
    assign dly_end  = start_reg + 32'(dly_units);
    assign run_over = (run_end - now) >> 31 != 32'd0;
    assign dly_over = (dly_end - now) >> 31 != 32'd0;

    // Command applied to this slot
    always_comb
    begin
        used_next    = used_reg;
        started_next = started_reg;
        playing_next = playing_reg;
        owner_next   = owner_reg;
        delay_next   = delay_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        start_next   = start_reg;
        op_next      = op_in;
        if (op_in.valid)
        begin
            case (op_in.cmd)
                CMD_UPLOAD:
                begin
                    if (!op_in.kind)
                    begin
                        if (op_in.alloc_new)
                        begin
                            if (!op_in.done && !used_reg)
                            begin
                                used_next      = 1'b1;
                                owner_next     = op_in.owner;
                                started_next   = 1'b0;
                                playing_next   = 1'b0;
                                delay_next     = op_in.delay;
                                length_next    = op_in.length;
                                op_next.status = STS_OK;
                                op_next.id     = IDX_W[2:0];
                                op_next.done   = 1'b1;
                            end
                        end
                        else if (match && touch)
                        begin
                            if ((started_reg || playing_reg) &&
                                (op_in.delay != delay_reg || op_in.length != length_reg))
                            begin
                                op_next.status = STS_NOSYS;
                            end
                            else
                            begin
                                delay_next     = op_in.delay;
                                length_next    = op_in.length;
                                op_next.status = STS_OK;
                                op_next.id     = IDX_W[2:0];
                            end
                        end
                    end
                end
                CMD_PLAY:
                begin
                    if (match && touch)
                    begin
                        if (op_in.value[31])
                        begin
                            op_next.status = STS_INVALID;
                        end
                        else if (op_in.value == 32'd0)
                        begin
                            started_next   = 1'b0;
                            playing_next   = 1'b0;
                            op_next.status = STS_OK;
                        end
                        else if (started_reg || playing_reg)
                        begin
                            op_next.status = STS_BUSY;
                        end
                        else
                        begin
                            count_next     = op_in.value[30:0];
                            start_next     = now;
                            started_next   = (delay_reg != 16'd0);
                            playing_next   = (delay_reg == 16'd0);
                            op_next.status = STS_OK;
                        end
                    end
                end
                CMD_ERASE:
                begin
                    if (match && touch)
                    begin
                        used_next      = 1'b0;
                        started_next   = 1'b0;
                        playing_next   = 1'b0;
                        op_next.status = STS_OK;
                    end
                end
                CMD_FLUSH:
                begin
                    if (used_reg && owner_reg == op_in.owner)
                    begin
                        used_next    = 1'b0;
                        started_next = 1'b0;
                        playing_next = 1'b0;
                    end
                end
                CMD_TICK:
                begin
                    if (playing_reg)
                    begin
                        op_next.any = 1'b1;
                        if (run_over)
                        begin
                            if (count_reg <= 31'd1)
                            begin
                                count_next   = 31'd0;
                                playing_next = 1'b0;
                            end
                            else
                            begin
                                count_next = count_reg - 31'd1;
                                if (length_reg != 16'd0)
                                begin
                                    playing_next = 1'b0;
                                    started_next = 1'b1;
                                end
                                start_next = now;
                            end
                        end
                    end
                    else if (started_reg && dly_over)
                    begin
                        started_next = 1'b0;
                        playing_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Flags and chain stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= 1'b0;
            started_reg <= 1'b0;
            playing_reg <= 1'b0;
            op_reg      <= '0;
        end
        else
        begin
            used_reg    <= used_next;
            started_reg <= started_next;
            playing_reg <= playing_next;
            op_reg      <= op_next;
        end
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        owner_reg  <= owner_next;
        delay_reg  <= delay_next;
        length_reg <= length_next;
        count_reg  <= count_next;
        start_reg  <= start_next;
    end

    assign op_out = op_reg;

endmodule
